### rtl/hssq_pkg.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer package
// Shared widths, register indexes, sequencer states, divider interface types
// and the eight-phase coil table.
// ----------------------------------------------------------------------------
package hssq_pkg;

   localparam int DIV_W    = 16;
   localparam int POS_W    = 16;
   localparam int RPM_W    = 10;
   localparam int COIL_W   = 4;
   localparam int PHASE_W  = 3;
   localparam int CNT_W    = 4;

   localparam logic [DIV_W-1:0] MS_PER_MINUTE = 16'd60000;
   localparam logic [POS_W-1:0] SPR_RESET     = 16'd4096;
   localparam logic [DIV_W-1:0] ELAPSED_MAX   = 16'hFFFF;

   localparam logic REG_STEPS_PER_REV = 1'b0;
   localparam logic REG_SPEED_RPM     = 1'b1;

   localparam logic KIND_MOVE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_SPR,
      ST_DIV_RPM
   } seq_state_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_stat_type;

   function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pat;
      case (phase)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage

### rtl/hssq_div.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer divider
// Restoring divider, one quotient bit per cycle, used for both divisions of
// the step delay.
// ----------------------------------------------------------------------------
module hssq_div
   import hssq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_req_type  req,
   output div_stat_type stat
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [DIV_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_W:0]      shifted;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = req.dividend;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DIV_W'(shifted - {1'b0, divisor_ff});
         end else begin
            rem_in = shifted[DIV_W-1:0];
         end
         quo_in   = {quo_ff[DIV_W-2:0], fits};
         count_in = CNT_W'(count_ff + 1'b1);
         if (count_ff == {CNT_W{1'b1}}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

### rtl/half_step_stepper_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Half-step stepper sequencer
// Eight-phase half-step driver for a four-coil unipolar stepper, with the
// step delay worked out by a shared iterative divider after each register
// write.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_*     in         tuser: kind; tdata: move_steps
//  rsp_*     out        tdata: coil_pattern, position, busy_res, stepped
//  csr_*     in/out     steps_per_rev at 0x0, speed_rpm at 0x4
//
// A request is taken and its result is registered at the same clock edge;
// one request per cycle is taken while the result side keeps up and no
// delay calculation runs. A register write starts two divisions in turn in
// the shared divider; the request side is held off until the delay is stored.
// Reset is synchronous and restores the register and state values.
// A stalled result holds and blocks the next request until it is taken.
// ----------------------------------------------------------------------------
module half_step_stepper_sequencer_unit
   import hssq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // move_steps[15:0]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // coil_pattern[3:0], position[19:4],
                                    // busy_res[20], stepped[21], zero[23:22]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   seq_state_type       state_ff, state_in;
   logic [POS_W-1:0]    spr_ff, spr_in;
   logic [RPM_W-1:0]    rpm_ff, rpm_in;
   logic [DIV_W-1:0]    delay_ff, delay_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                fwd_ff, fwd_in;
   logic [POS_W-1:0]    remain_ff, remain_in;
   logic [DIV_W-1:0]    elapsed_ff, elapsed_in;
   logic [COIL_W-1:0]   coil_ff, coil_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [23:0]         rsp_data_ff, rsp_data_in;

   logic                cfg_write;
   logic                req_fire;
   logic                halted;
   logic                step_taken;
   logic [DIV_W-1:0]    elapsed_inc;
   div_req_type         div_req;
   div_stat_type        div_stat;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_SPEED_RPM) ? {22'd0, rpm_ff} : {16'd0, spr_ff};

   always_comb begin
      spr_in = spr_ff;
      rpm_in = rpm_ff;
      if (cfg_write) begin
         if (csr_paddr[2] == REG_STEPS_PER_REV) begin
            spr_in = csr_pwdata[POS_W-1:0];
         end else begin
            rpm_in = csr_pwdata[RPM_W-1:0];
         end
      end
   end

   hssq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .stat  (div_stat)
   );

   // Sequencer: next state
   always_comb begin
      state_in = state_ff;
      if (cfg_write) begin
         state_in = ST_DIV_SPR;
      end else begin
         case (state_ff)
            ST_IDLE:    state_in = ST_IDLE;
            ST_DIV_SPR: if (div_stat.done) state_in = ST_DIV_RPM;
            ST_DIV_RPM: if (div_stat.done) state_in = ST_IDLE;
            default:    state_in = ST_IDLE;
         endcase
      end
   end

   // Sequencer: outputs
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = MS_PER_MINUTE;
      div_req.divisor  = spr_in;
      delay_in         = delay_ff;
      if (cfg_write) begin
         div_req.start = 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
            end
            ST_DIV_SPR: begin
               div_req.start    = div_stat.done;
               div_req.dividend = div_stat.quotient;
               div_req.divisor  = {{(DIV_W-RPM_W){1'b0}}, rpm_ff};
            end
            ST_DIV_RPM: begin
               if (div_stat.done) begin
                  delay_in = div_stat.quotient;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign halted      = (rpm_ff == '0) || (spr_ff == '0);
   assign elapsed_inc = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : DIV_W'(elapsed_ff + 1'b1);
   assign step_taken  = req_fire && (req_tuser == KIND_TICK) && (remain_ff != '0)
                        && !halted && (elapsed_inc >= delay_ff);

   always_comb begin
      pos_in       = pos_ff;
      fwd_in       = fwd_ff;
      remain_in    = remain_ff;
      elapsed_in   = elapsed_ff;
      coil_in      = coil_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         if (req_tuser == KIND_MOVE) begin
            if (req_tdata[15]) begin
               fwd_in    = 1'b0;
               remain_in = POS_W'(~req_tdata + 1'b1);
            end else begin
               if (req_tdata != '0) begin
                  fwd_in = 1'b1;
               end
               remain_in = req_tdata;
            end
         end else begin
            elapsed_in = elapsed_inc;
            if (step_taken) begin
               if (fwd_ff) begin
                  if (({1'b0, pos_ff} + 17'd1) >= {1'b0, spr_ff}) begin
                     pos_in = '0;
                  end else begin
                     pos_in = POS_W'(pos_ff + 1'b1);
                  end
               end else begin
                  if ((pos_ff == '0) || (pos_ff >= spr_ff)) begin
                     pos_in = POS_W'(spr_ff - 1'b1);
                  end else begin
                     pos_in = POS_W'(pos_ff - 1'b1);
                  end
               end
               remain_in  = POS_W'(remain_ff - 1'b1);
               coil_in    = coil_of(pos_in[PHASE_W-1:0]);
               elapsed_in = '0;
            end
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, step_taken, (remain_in != '0), pos_in, coil_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spr_ff       <= SPR_RESET;
         rpm_ff       <= '0;
         delay_ff     <= '0;
         pos_ff       <= '0;
         fwd_ff       <= 1'b0;
         remain_ff    <= '0;
         elapsed_ff   <= '0;
         coil_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spr_ff       <= spr_in;
         rpm_ff       <= rpm_in;
         delay_ff     <= delay_in;
         pos_ff       <= pos_in;
         fwd_ff       <= fwd_in;
         remain_ff    <= remain_in;
         elapsed_ff   <= elapsed_in;
         coil_ff      <= coil_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   a_div_not_idle: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff != ST_IDLE))
      else $error("divider running while the sequencer is idle");

   a_write_restarts: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (state_ff == ST_DIV_SPR) && div_stat.busy)
      else $error("register write did not restart the delay calculation");

   a_move_no_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_MOVE)) |=> !rsp_data_ff[21])
      else $error("a move request reported a step");

   a_step_counts_down: assert property (@(posedge clock) disable iff (reset)
      step_taken |=> (remain_ff == POS_W'($past(remain_ff) - 1'b1)) && (elapsed_ff == '0))
      else $error("a step did not consume one remaining step");

endmodule
